// ===== hw/rtl/crm_pkg.sv =====
// Shared types and codes for the 3x3 Cramer's rule solver.
// No dependencies; used by the top level through scoped names.
package crm_pkg;

    localparam int OUT_W = 48;

    localparam logic [1:0] STATUS_UNIQUE   = 2'd0;
    localparam logic [1:0] STATUS_INFINITE = 2'd1;
    localparam logic [1:0] STATUS_NONE     = 2'd2;

    typedef struct packed {
        logic [1:0] status;
        logic [2:0] neg;
    } side_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] x;
        logic signed [OUT_W-1:0] y;
        logic signed [OUT_W-1:0] z;
        logic [1:0]              status;
        logic                    sat;
    } result_t;

endpackage

// ===== hw/rtl/crm_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, unsigned operands.
// Standalone; instantiated once per unknown by cramer_3x3_linear_solver.
module crm_div #(
    parameter int DVD_W = 66,
    parameter int DVS_W = 50
) (
    input  logic             clk,
    input  logic             en,
    input  logic [DVD_W-1:0] dvd,
    input  logic [DVS_W-1:0] dvs,
    output logic [DVD_W-1:0] quo
);

    logic [DVS_W-1:0] rem_reg [DVD_W];
    logic [DVD_W-1:0] nq_reg  [DVD_W];
    logic [DVS_W-1:0] dvs_reg [DVD_W];

    logic [DVS_W-1:0] rem_next [DVD_W];
    logic [DVD_W-1:0] nq_next  [DVD_W];

    genvar g;
    generate
        for (g = 0; g < DVD_W; g++)
        begin : g_stage
            logic [DVS_W-1:0] src_rem;
            logic [DVD_W-1:0] src_nq;
            logic [DVS_W-1:0] src_dvs;
            logic [DVS_W:0]   trial;
            logic             ge;

            if (g == 0)
            begin : g_first
                assign src_rem = '0;
                assign src_nq  = dvd;
                assign src_dvs = dvs;
            end
            else
            begin : g_rest
                assign src_rem = rem_reg[g-1];
                assign src_nq  = nq_reg[g-1];
                assign src_dvs = dvs_reg[g-1];
            end

            // shift in the next dividend bit, subtract when it fits
            always_comb
            begin
                trial = {src_rem, src_nq[DVD_W-1]};
                ge    = (trial >= {1'b0, src_dvs});
                if (ge)
                    rem_next[g] = DVS_W'(trial - {1'b0, src_dvs});
                else
                    rem_next[g] = DVS_W'(trial);
                nq_next[g] = {src_nq[DVD_W-2:0], ge};
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[g] <= rem_next[g];
                    nq_reg[g]  <= nq_next[g];
                    dvs_reg[g] <= src_dvs;
                end
            end
        end
    endgenerate

    assign quo = nq_reg[DVD_W-1];

endmodule

// ===== hw/rtl/cramer_3x3_linear_solver.sv =====
// Path: an accepted word passes the capture, product, minor, term and determinant stages,
// then the bit-per-stage dividers and the format and output registers, to result_valid.
// Throughput: one system per cycle while coef_stall is low; a two-entry output register
// and skid stage hold results, and coef_stall rises only when both are full.
// Reset (rst_n low, asynchronous) clears every valid bit; payload is not reset.
// Depends on crm_pkg and crm_div.
module cramer_3x3_linear_solver #(
    parameter int COEF_WIDTH = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               coef_valid,
    output logic                               coef_stall,
    input  logic signed [COEF_WIDTH-1:0]       a1,
    input  logic signed [COEF_WIDTH-1:0]       b1,
    input  logic signed [COEF_WIDTH-1:0]       c1,
    input  logic signed [COEF_WIDTH-1:0]       d1,
    input  logic signed [COEF_WIDTH-1:0]       a2,
    input  logic signed [COEF_WIDTH-1:0]       b2,
    input  logic signed [COEF_WIDTH-1:0]       c2,
    input  logic signed [COEF_WIDTH-1:0]       d2,
    input  logic signed [COEF_WIDTH-1:0]       a3,
    input  logic signed [COEF_WIDTH-1:0]       b3,
    input  logic signed [COEF_WIDTH-1:0]       c3,
    input  logic signed [COEF_WIDTH-1:0]       d3,
    output logic                               result_valid,
    input  logic                               result_stall,
    output logic signed [crm_pkg::OUT_W-1:0]   x_value,
    output logic signed [crm_pkg::OUT_W-1:0]   y_value,
    output logic signed [crm_pkg::OUT_W-1:0]   z_value,
    output logic [1:0]                         status,
    output logic                               saturated
);

    localparam int W   = COEF_WIDTH;
    localparam int PW  = 2 * W;
    localparam int MNW = 2 * W + 1;
    localparam int TW  = 3 * W + 1;
    localparam int DW  = 3 * W + 3;
    localparam int MW  = 3 * W + 2;
    localparam int NB  = MW + FRAC_BITS;
    localparam int OW  = crm_pkg::OUT_W;
    localparam int EW  = ((NB > OW) ? NB : OW) + 1;

    // column codes and the six 2x2 minors of rows 2 and 3
    localparam int COL_A = 0;
    localparam int COL_B = 1;
    localparam int COL_C = 2;
    localparam int COL_D = 3;
    localparam int M_BC = 0;
    localparam int M_AC = 1;
    localparam int M_AB = 2;
    localparam int M_DC = 3;
    localparam int M_BD = 4;
    localparam int M_AD = 5;
    localparam int MP [6] = '{COL_B, COL_A, COL_A, COL_D, COL_B, COL_A};
    localparam int MQ [6] = '{COL_C, COL_C, COL_B, COL_C, COL_D, COL_D};
    // row 1 column and minor for each term of D, Dx, Dy, Dz
    localparam int TC [12] = '{COL_A, COL_B, COL_C, COL_D, COL_B, COL_C,
                               COL_A, COL_D, COL_C, COL_A, COL_B, COL_D};
    localparam int TM [12] = '{M_BC, M_AC, M_AB, M_BC, M_DC, M_BD,
                               M_DC, M_AC, M_AD, M_BD, M_AD, M_AB};

    logic adv;
    logic [4:0] v_reg;

    logic signed [W-1:0]   cf_reg [12];
    logic signed [W-1:0]   cf_next [12];
    logic signed [W-1:0]   r1s2_reg [4];
    logic signed [PW-1:0]  pr_reg [12];
    logic signed [PW-1:0]  pr_next [12];
    logic signed [W-1:0]   r1s3_reg [4];
    logic signed [MNW-1:0] mn_reg [6];
    logic signed [MNW-1:0] mn_next [6];
    logic signed [TW-1:0]  tp_reg [12];
    logic signed [TW-1:0]  tp_next [12];
    logic signed [DW-1:0]  dt_reg [4];
    logic signed [DW-1:0]  dt_next [4];

    // stage 1: capture the word
    assign cf_next = '{a1, b1, c1, d1, a2, b2, c2, d2, a3, b3, c3, d3};

    // stage 2: products of rows 2 and 3
    always_comb
    begin
        for (int k = 0; k < 6; k++)
        begin
            pr_next[2*k]   = PW'(cf_reg[4+MP[k]]) * PW'(cf_reg[8+MQ[k]]);
            pr_next[2*k+1] = PW'(cf_reg[4+MQ[k]]) * PW'(cf_reg[8+MP[k]]);
        end
    end

    // stage 3: minors
    always_comb
    begin
        for (int k = 0; k < 6; k++)
            mn_next[k] = MNW'(pr_reg[2*k]) - MNW'(pr_reg[2*k+1]);
    end

    // stage 4: row 1 times minors
    always_comb
    begin
        for (int k = 0; k < 12; k++)
            tp_next[k] = TW'(r1s3_reg[TC[k]]) * TW'(mn_reg[TM[k]]);
    end

    // stage 5: D, Dx, Dy, Dz (Dx subtracts the minor of b,d, the negation of d,b)
    always_comb
    begin
        dt_next[0] = DW'(tp_reg[0]) - DW'(tp_reg[1]) + DW'(tp_reg[2]);
        dt_next[1] = DW'(tp_reg[3]) - DW'(tp_reg[4]) - DW'(tp_reg[5]);
        dt_next[2] = DW'(tp_reg[6]) - DW'(tp_reg[7]) + DW'(tp_reg[8]);
        dt_next[3] = DW'(tp_reg[9]) - DW'(tp_reg[10]) + DW'(tp_reg[11]);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cf_reg   <= cf_next;
            r1s2_reg <= cf_reg[0:3];
            pr_reg   <= pr_next;
            r1s3_reg <= r1s2_reg;
            mn_reg   <= mn_next;
            tp_reg   <= tp_next;
            dt_reg   <= dt_next;
        end
    end

    // divider feed: magnitudes, quotient signs and classification
    logic [MW-1:0]   dvs_mag;
    logic [NB-1:0]   dvd_num [3];
    crm_pkg::side_t  side_next;

    always_comb
    begin
        dvs_mag = dt_reg[0][DW-1] ? MW'(-dt_reg[0]) : MW'(dt_reg[0]);
        for (int l = 0; l < 3; l++)
        begin
            dvd_num[l] = dt_reg[l+1][DW-1] ? (NB'(MW'(-dt_reg[l+1])) << FRAC_BITS)
                                           : (NB'(MW'(dt_reg[l+1])) << FRAC_BITS);
            side_next.neg[l] = dt_reg[l+1][DW-1] ^ dt_reg[0][DW-1];
        end
        if (dt_reg[0] != '0)
            side_next.status = crm_pkg::STATUS_UNIQUE;
        else if (dt_reg[1] == '0 || dt_reg[2] == '0 || dt_reg[3] == '0)
            side_next.status = crm_pkg::STATUS_INFINITE;
        else
            side_next.status = crm_pkg::STATUS_NONE;
    end

    logic [NB-1:0] quo [3];

    genvar gl;
    generate
        for (gl = 0; gl < 3; gl++)
        begin : g_lane
            crm_div #(
                .DVD_W (NB),
                .DVS_W (MW)
            ) u_div (
                .clk (clk),
                .en  (adv),
                .dvd (dvd_num[gl]),
                .dvs (dvs_mag),
                .quo (quo[gl])
            );
        end
    endgenerate

    // side line that travels alongside the divider stages
    logic [NB-1:0]  sv_reg;
    crm_pkg::side_t sd_reg [NB];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sd_reg[0] <= side_next;
            for (int i = 1; i < NB; i++)
                sd_reg[i] <= sd_reg[i-1];
        end
    end

    // format: sign, saturate, zero on a singular system
    crm_pkg::result_t p_next;
    crm_pkg::result_t p_reg;
    logic             pv_reg;
    logic [EW-1:0]    qe;
    logic [EW-1:0]    lim;
    logic [OW-1:0]    lane_val [3];
    logic [2:0]       lane_sat;

    always_comb
    begin
        lim = EW'(1) << (OW - 1);
        for (int l = 0; l < 3; l++)
        begin
            qe = EW'(quo[l]);
            lane_sat[l] = 1'b0;
            if (sd_reg[NB-1].neg[l])
            begin
                if (qe > lim)
                begin
                    lane_sat[l] = 1'b1;
                    lane_val[l] = OW'(-lim);
                end
                else
                    lane_val[l] = OW'(-qe);
            end
            else
            begin
                if (qe > lim - EW'(1))
                begin
                    lane_sat[l] = 1'b1;
                    lane_val[l] = OW'(lim - EW'(1));
                end
                else
                    lane_val[l] = OW'(qe);
            end
        end
        p_next.status = sd_reg[NB-1].status;
        if (sd_reg[NB-1].status == crm_pkg::STATUS_UNIQUE)
        begin
            p_next.x   = lane_val[0];
            p_next.y   = lane_val[1];
            p_next.z   = lane_val[2];
            p_next.sat = |lane_sat;
        end
        else
        begin
            p_next.x   = '0;
            p_next.y   = '0;
            p_next.z   = '0;
            p_next.sat = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            p_reg <= p_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg  <= '0;
            sv_reg <= '0;
            pv_reg <= 1'b0;
        end
        else if (adv)
        begin
            v_reg  <= {v_reg[3:0], coef_valid};
            sv_reg <= {sv_reg[NB-2:0], v_reg[4]};
            pv_reg <= sv_reg[NB-1];
        end
    end

    // output register with a skid entry behind it
    crm_pkg::result_t out_reg;
    crm_pkg::result_t out_next;
    crm_pkg::result_t skid_reg;
    crm_pkg::result_t skid_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             skid_full_reg;
    logic             skid_full_next;
    logic             take;

    assign adv  = !skid_full_reg;
    assign take = out_valid_reg && !result_stall;

    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        skid_next      = skid_reg;
        skid_full_next = skid_full_reg;
        if (!out_valid_reg || take)
        begin
            if (skid_full_reg)
            begin
                out_next       = skid_reg;
                out_valid_next = 1'b1;
                skid_full_next = 1'b0;
            end
            else
            begin
                out_next       = p_reg;
                out_valid_next = pv_reg;
            end
        end
        else if (pv_reg && !skid_full_reg)
        begin
            // hold the word leaving the pipe while the output is stalled
            skid_next      = p_reg;
            skid_full_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            skid_full_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            skid_full_reg <= skid_full_next;
        end
    end

    assign coef_stall   = skid_full_reg;
    assign result_valid = out_valid_reg;
    assign x_value      = out_reg.x;
    assign y_value      = out_reg.y;
    assign z_value      = out_reg.z;
    assign status       = out_reg.status;
    assign saturated    = out_reg.sat;

`ifndef SYNTHESIS
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_full_reg |-> out_valid_reg)
        else $error("skid entry full while output register empty");

    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_full_reg) |-> $past(out_valid_reg && result_stall))
        else $error("skid filled without a stalled output");

    a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && status != crm_pkg::STATUS_UNIQUE |->
            x_value == '0 && y_value == '0 && z_value == '0 && !saturated)
        else $error("singular system carries nonzero values");

    a_sat_unique: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && saturated |-> status == crm_pkg::STATUS_UNIQUE)
        else $error("saturation flagged without a unique solution");
`endif

endmodule
